[rtl/sbr_pkg.sv]
// Shared types and constants of the spectrum bar pixel renderer.
// Holds the work item format, divider request, color endpoints and the gradient curve table.
// No dependencies; every other file imports this package.
`default_nettype none

package sbr_pkg;

  localparam int MAG_W     = 17;
  localparam int BAND_W    = 5;
  localparam int COORD_W   = 10;
  localparam int COLOR_W   = 8;
  localparam int CURVE_W   = 13;
  localparam int MAGIN_W   = 18;

  localparam logic [MAG_W-1:0]   MAG_ONE   = 17'd65536;
  localparam logic [CURVE_W-1:0] CURVE_ONE = 13'd4096;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 10;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd1;
  localparam logic [COORD_W-1:0]     FRAME_HEIGHT_RST = 10'd64;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [BAND_W-1:0]  band;
    logic [MAG_W-1:0]   mag;
    logic [COORD_W-1:0] vband;
    logic [COORD_W-1:0] row;
  } work_t;

  localparam int QUEUE_DEPTH = 2;

  // Gradient position divider: two quotient bits per cycle.
  localparam int DIV_NUM_W  = 24;
  localparam int DIV_DEN_W  = 11;
  localparam int DIV_QUOT_W = 14;
  localparam int DIV_STEPS  = 7;

  typedef struct packed {
    logic                  start;
    logic [DIV_NUM_W-1:0]  dividend;
    logic [DIV_DEN_W-1:0]  divisor;
  } div_req_t;

  localparam logic [COLOR_W-1:0] BG_RED   = 8'd25;
  localparam logic [COLOR_W-1:0] BG_GREEN = 8'd15;
  localparam logic [COLOR_W-1:0] BG_BLUE  = 8'd35;
  localparam logic [COLOR_W-1:0] RED_HI   = 8'd255;
  localparam logic [COLOR_W-1:0] RED_LO   = 8'd0;
  localparam logic [COLOR_W-1:0] GREEN_HI = 8'd0;
  localparam logic [COLOR_W-1:0] GREEN_LO = 8'd150;
  localparam logic [COLOR_W-1:0] BLUE_HI  = 8'd180;
  localparam logic [COLOR_W-1:0] BLUE_LO  = 8'd255;

  // 4096 * (idx/32)^0.7, rounded.
  function automatic logic [CURVE_W-1:0] pow_curve(input logic [5:0] idx);
    logic [CURVE_W-1:0] val;
    case (idx)
      6'd0:  val = 13'd0;
      6'd1:  val = 13'd362;
      6'd2:  val = 13'd588;
      6'd3:  val = 13'd781;
      6'd4:  val = 13'd955;
      6'd5:  val = 13'd1117;
      6'd6:  val = 13'd1269;
      6'd7:  val = 13'd1414;
      6'd8:  val = 13'd1552;
      6'd9:  val = 13'd1685;
      6'd10: val = 13'd1814;
      6'd11: val = 13'd1940;
      6'd12: val = 13'd2061;
      6'd13: val = 13'd2180;
      6'd14: val = 13'd2296;
      6'd15: val = 13'd2410;
      6'd16: val = 13'd2521;
      6'd17: val = 13'd2631;
      6'd18: val = 13'd2738;
      6'd19: val = 13'd2844;
      6'd20: val = 13'd2948;
      6'd21: val = 13'd3050;
      6'd22: val = 13'd3151;
      6'd23: val = 13'd3251;
      6'd24: val = 13'd3349;
      6'd25: val = 13'd3446;
      6'd26: val = 13'd3542;
      6'd27: val = 13'd3637;
      6'd28: val = 13'd3730;
      6'd29: val = 13'd3823;
      6'd30: val = 13'd3915;
      6'd31: val = 13'd4006;
      default: val = 13'd4096;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[rtl/sbr_ifs.sv]
// Handshake channels of the spectrum bar pixel renderer: request, response and config write.
// Each carries valid, ready and its payload. Depends on sbr_pkg for field widths.
`default_nettype none

interface sbr_req_if;
  import sbr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [BAND_W-1:0]         band_number;
  logic signed [MAGIN_W-1:0] magnitude;
  logic [COORD_W-1:0]        column;
  logic [COORD_W-1:0]        row;
  modport source (output valid, cmd, band_number, magnitude, column, row, input ready);
  modport sink   (input valid, cmd, band_number, magnitude, column, row, output ready);
endinterface

interface sbr_rsp_if;
  import sbr_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               inside_bar;
  modport source (output valid, red, green, blue, inside_bar, input ready);
  modport sink   (input valid, red, green, blue, inside_bar, output ready);
endinterface

interface sbr_cfg_if;
  import sbr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/sbr_front.sv]
// Front end: accepts request items, clamps magnitudes and folds columns onto visual bands.
// Depends on sbr_pkg and sbr_ifs; feeds sbr_queue.
`default_nettype none

module sbr_front #(
  parameter int BAND_COUNT        = 32,
  parameter int VISUAL_BAND_COUNT = 128
) (
  sbr_req_if.sink        req,
  input  logic           space,
  output logic           push,
  output sbr_pkg::work_t item
);
  import sbr_pkg::*;

  logic signed [COORD_W+1:0] col_s;
  logic signed [COORD_W+1:0] mirror;
  logic signed [COORD_W+1:0] fold;
  logic [MAG_W-1:0]          mag_clamped;
  logic                      keep;

  assign req.ready = space;

  always_comb begin
    if (req.magnitude < 0) begin
      mag_clamped = '0;
    end else if (req.magnitude > $signed({1'b0, MAG_ONE})) begin
      mag_clamped = MAG_ONE;
    end else begin
      mag_clamped = req.magnitude[MAG_W-1:0];
    end
  end

  // The right half of the frame mirrors the left half.
  always_comb begin
    col_s  = $signed({2'b00, req.column});
    mirror = $signed((COORD_W+2)'(2 * VISUAL_BAND_COUNT - 1)) - col_s;
    fold   = (col_s < mirror) ? col_s : mirror;
  end

  always_comb begin
    item.op   = op_t'(req.cmd);
    item.band = req.band_number;
    item.mag  = mag_clamped;
    item.row  = req.row;
    if (fold < 0) begin
      item.vband = '0;
    end else if (fold > $signed((COORD_W+2)'(VISUAL_BAND_COUNT - 1))) begin
      item.vband = COORD_W'(VISUAL_BAND_COUNT - 1);
    end else begin
      item.vband = fold[COORD_W-1:0];
    end
  end

  // Writes to bands beyond the store are taken and dropped here.
  assign keep = (op_t'(req.cmd) == OP_RENDER) ||
                ({3'b000, req.band_number} < 8'(BAND_COUNT - 1) + 8'd1) ||
                (BAND_COUNT > 255);
  assign push = req.valid && space && keep;

endmodule

`default_nettype wire

[rtl/sbr_queue.sv]
// Short queue of classified work items between the front end and the back end.
// Depends on sbr_pkg for the item type and depth.
`default_nettype none

module sbr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sbr_pkg::work_t push_item,
  output logic           space,
  input  logic           pop,
  output logic           avail,
  output sbr_pkg::work_t head
);
  import sbr_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  work_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign space = (count != CW'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && count == CW'(QUEUE_DEPTH)))
    else $error("item pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("item popped from an empty queue");

endmodule

`default_nettype wire

[rtl/sbr_divider.sv]
// Restoring divider that forms the gradient position, two quotient bits per cycle.
// Depends on sbr_pkg for the request type and widths; used by sbr_back.
`default_nettype none

module sbr_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sbr_pkg::div_req_t                    req,
  output logic                                 busy,
  output logic [sbr_pkg::DIV_QUOT_W-1:0]       quotient
);
  import sbr_pkg::*;

  localparam int SC_W = $clog2(DIV_STEPS + 1);

  logic [DIV_DEN_W-1:0]  acc;
  logic [DIV_DEN_W-1:0]  den;
  logic [DIV_QUOT_W-1:0] shreg;
  logic [SC_W-1:0]       steps;

  logic [DIV_DEN_W:0]    trial1;
  logic [DIV_DEN_W:0]    trial2;
  logic                  ge1;
  logic                  ge2;
  logic [DIV_DEN_W-1:0]  acc1;
  logic [DIV_DEN_W-1:0]  acc2;

  // The low dividend bits shift out of shreg as quotient bits shift in.
  always_comb begin
    trial1 = {acc, shreg[DIV_QUOT_W-1]};
    ge1    = trial1 >= {1'b0, den};
    acc1   = ge1 ? DIV_DEN_W'(trial1 - {1'b0, den}) : trial1[DIV_DEN_W-1:0];
    trial2 = {acc1, shreg[DIV_QUOT_W-2]};
    ge2    = trial2 >= {1'b0, den};
    acc2   = ge2 ? DIV_DEN_W'(trial2 - {1'b0, den}) : trial2[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc   <= DIV_DEN_W'(req.dividend[DIV_NUM_W-1:DIV_QUOT_W]);
      shreg <= req.dividend[DIV_QUOT_W-1:0];
      den   <= req.divisor;
    end else if (busy) begin
      acc   <= acc2;
      shreg <= {shreg[DIV_QUOT_W-3:0], ge1, ge2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      steps <= SC_W'(DIV_STEPS);
    end else if (busy) begin
      steps <= steps - SC_W'(1);
      if (steps == SC_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = shreg;

endmodule

`default_nettype wire

[rtl/sbr_back.sv]
// Back end: band store, bar height, gradient position and color blending, one item at a time.
// Depends on sbr_pkg and sbr_ifs; drives sbr_divider and the response channel.
`default_nettype none

module sbr_back #(
  parameter int BAND_COUNT   = 32,
  parameter int INTERP_STEPS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [sbr_pkg::COORD_W-1:0]      frame_height,
  input  logic                             q_avail,
  input  sbr_pkg::work_t                   q_item,
  output logic                             q_pop,
  output sbr_pkg::div_req_t                div_req,
  input  logic                             div_busy,
  input  logic [sbr_pkg::DIV_QUOT_W-1:0]   div_quot,
  sbr_rsp_if.source                        rsp
);
  import sbr_pkg::*;

  localparam int AW      = $clog2(BAND_COUNT);
  localparam int SW      = $clog2(INTERP_STEPS + 1);
  localparam int NUM_W   = MAG_W + SW;
  localparam int PROD_W  = NUM_W + COORD_W;
  localparam int RND_W   = PROD_W + 1;
  localparam int RECIP   = 65536 / INTERP_STEPS;
  localparam int HALF    = INTERP_STEPS * 32768;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SPLIT = 4'd1;
  localparam logic [3:0] ST_READ  = 4'd2;
  localparam logic [3:0] ST_MIX   = 4'd3;
  localparam logic [3:0] ST_SCALE = 4'd4;
  localparam logic [3:0] ST_BAR   = 4'd5;
  localparam logic [3:0] ST_TEST  = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  // Quotient by INTERP_STEPS through the reciprocal; one correction covers the truncation.
  function automatic logic [COORD_W-1:0] steps_quot(input logic [15:0] val);
    logic [32:0]          scaled;
    logic [COORD_W-1:0]   q;
    logic [15:0]          left;
    scaled = 33'(val) * 33'(RECIP);
    q      = scaled[16+COORD_W-1:16];
    left   = val - 16'(q * INTERP_STEPS);
    if (left >= 16'(INTERP_STEPS)) begin
      q = q + COORD_W'(1);
    end
    return q;
  endfunction

  logic [3:0]           state;
  logic [3:0]           state_next;

  logic [MAG_W-1:0]     band_mem [BAND_COUNT];
  logic [BAND_COUNT-1:0] band_ok;

  logic [COORD_W-1:0]   vband;
  logic [COORD_W-1:0]   row;
  logic [AW-1:0]        addr1;
  logic [AW-1:0]        addr2;
  logic [SW-1:0]        step;
  logic [MAG_W-1:0]     m1_raw;
  logic [MAG_W-1:0]     m2_raw;
  logic                 m1_ok;
  logic                 m2_ok;
  logic [NUM_W-1:0]     num;
  logic [PROD_W-1:0]    prod;
  logic [COORD_W-1:0]   bar;
  logic [CURVE_W-1:0]   curve;
  logic                 background;

  logic                 out_valid;
  logic [COLOR_W-1:0]   out_red;
  logic [COLOR_W-1:0]   out_green;
  logic [COLOR_W-1:0]   out_blue;
  logic                 out_inside;
  logic                 out_free;

  // Combinational values of the individual steps.
  logic [COORD_W-1:0]   split_q;
  logic [COORD_W-1:0]   split_b;
  logic [COORD_W-1:0]   split_s;
  logic                 has_next;
  logic [MAG_W-1:0]     m1;
  logic [MAG_W-1:0]     m2;
  logic [RND_W-1:0]     rounded;
  logic [COORD_W-1:0]   bar_q;
  logic [COORD_W-1:0]   top_rows;
  logic signed [COORD_W:0] rem;
  logic [COORD_W-1:0]   safe_bar;
  logic [DIV_QUOT_W-1:0] n_sat;
  logic [CURVE_W-1:0]   n;
  logic [CURVE_W-1:0]   t0;
  logic [CURVE_W-1:0]   t1;
  logic [CURVE_W+6:0]   frac_prod;
  logic [CURVE_W-1:0]   curve_new;
  logic [CURVE_W-1:0]   curve_inv;
  logic [20:0]          red_sum;
  logic [20:0]          green_sum;
  logic [20:0]          blue_sum;

  assign q_pop    = (state == ST_IDLE) && q_avail;
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    split_q  = steps_quot({6'b0, vband});
    split_s  = vband - COORD_W'(split_q * INTERP_STEPS);
    split_b  = (split_q > COORD_W'(BAND_COUNT - 1)) ? COORD_W'(BAND_COUNT - 1) : split_q;
    has_next = (split_s != '0) && (split_b < COORD_W'(BAND_COUNT - 1));
  end

  assign m1 = m1_ok ? m1_raw : '0;
  assign m2 = m2_ok ? m2_raw : '0;

  always_comb begin
    rounded = {1'b0, prod} + RND_W'(HALF);
    bar_q   = steps_quot(16'(rounded >> 16));
  end

  always_comb begin
    top_rows = frame_height - bar;
    rem      = $signed({1'b0, frame_height}) - $signed({1'b0, row});
    safe_bar = (bar == '0) ? COORD_W'(1) : bar;
  end

  always_comb begin
    div_req.start    = (state == ST_TEST) && !(row < top_rows) && (rem > 0);
    div_req.dividend = {1'b0, rem[COORD_W-1:0], 13'b0} + DIV_NUM_W'(safe_bar);
    div_req.divisor  = {safe_bar, 1'b0};
  end

  // Power curve by linear interpolation between table points.
  always_comb begin
    n_sat     = (div_quot > DIV_QUOT_W'(CURVE_ONE)) ? DIV_QUOT_W'(CURVE_ONE) : div_quot;
    n         = n_sat[CURVE_W-1:0];
    t0        = pow_curve(n[CURVE_W-1:7]);
    t1        = pow_curve(n[CURVE_W-1:7] + 6'd1);
    frac_prod = (CURVE_W+7)'(t1 - t0) * (CURVE_W+7)'(n[6:0]) + (CURVE_W+7)'(64);
    if (n[CURVE_W-1]) begin
      curve_new = CURVE_ONE;
    end else begin
      curve_new = t0 + CURVE_W'(frac_prod >> 7);
    end
  end

  always_comb begin
    curve_inv = CURVE_ONE - curve;
    red_sum   = 21'(RED_HI) * 21'(curve) + 21'(RED_LO) * 21'(curve_inv) + 21'd2048;
    green_sum = 21'(GREEN_HI) * 21'(curve) + 21'(GREEN_LO) * 21'(curve_inv) + 21'd2048;
    blue_sum  = 21'(BLUE_HI) * 21'(curve) + 21'(BLUE_LO) * 21'(curve_inv) + 21'd2048;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_avail && q_item.op == OP_RENDER) begin
          state_next = ST_SPLIT;
        end
      end
      ST_SPLIT: state_next = ST_READ;
      ST_READ:  state_next = ST_MIX;
      ST_MIX:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_BAR;
      ST_BAR:   state_next = ST_TEST;
      ST_TEST:  state_next = div_req.start ? ST_DIV : ST_EMIT;
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Band store; entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == OP_WRITE) begin
      band_mem[AW'(q_item.band)] <= q_item.mag;
    end
    m1_raw <= band_mem[addr1];
    m2_raw <= band_mem[addr2];
    m1_ok  <= band_ok[addr1];
    m2_ok  <= band_ok[addr2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_ok <= '0;
    end else if (q_pop && q_item.op == OP_WRITE) begin
      band_ok[AW'(q_item.band)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      vband <= q_item.vband;
      row   <= q_item.row;
    end
    if (state == ST_SPLIT) begin
      addr1 <= AW'(split_b);
      addr2 <= has_next ? AW'(split_b + COORD_W'(1)) : AW'(split_b);
      step  <= SW'(split_s);
    end
    if (state == ST_MIX) begin
      num <= NUM_W'(m1) * NUM_W'(SW'(INTERP_STEPS) - step) + NUM_W'(m2) * NUM_W'(step);
    end
    if (state == ST_SCALE) begin
      prod <= PROD_W'(num) * PROD_W'(frame_height);
    end
    if (state == ST_BAR) begin
      bar <= (bar_q > frame_height) ? frame_height : bar_q;
    end
    if (state == ST_TEST) begin
      background <= (row < top_rows);
      curve      <= '0;
    end
    if (state == ST_DIV && !div_busy) begin
      curve <= curve_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      if (background) begin
        out_red    <= BG_RED;
        out_green  <= BG_GREEN;
        out_blue   <= BG_BLUE;
        out_inside <= 1'b0;
      end else begin
        out_red    <= red_sum[19:12];
        out_green  <= green_sum[19:12];
        out_blue   <= blue_sum[19:12];
        out_inside <= 1'b1;
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.red        = out_red;
  assign rsp.green      = out_green;
  assign rsp.blue       = out_blue;
  assign rsp.inside_bar = out_inside;

  a_bar_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_TEST |-> bar <= frame_height)
    else $error("bar height exceeds frame height");

  a_div_started: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST && div_req.start) |=> (state == ST_DIV && div_busy))
    else $error("divider not running after start");

  a_curve_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !background) |-> curve <= CURVE_ONE)
    else $error("curve value out of range");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("result not loaded into output register");

endmodule

`default_nettype wire

[rtl/spectrum_bar_pixel_renderer.sv]
// Top level of the spectrum bar pixel renderer: config registers and the front/queue/back chain.
// Depends on sbr_pkg, sbr_ifs, sbr_front, sbr_queue, sbr_divider and sbr_back.
//
// Band writes (cmd 0) update a store of BAND_COUNT magnitudes and give no response; pixel
// requests (cmd 1) give one response with the pixel color and an inside-bar flag. Requests
// are accepted into a two-entry queue whenever it has room, so a waiting response does not
// block new requests until the queue fills. The back end handles one item at a time: a band
// write is stored as it is taken from the queue, and a pixel inside the bar passes the band
// lookup, bar height and blending steps and the two-bit-per-cycle divider (seven steps, then
// the result is taken) that finds the pixel's place in the bar gradient. A background pixel,
// or one at or below the frame bottom, skips the divider. A response that is not taken holds
// the back end in its last step. The band store clears at once on reset through one valid
// flag per band, so no clearing pass is needed. frame_height sets the full bar height;
// frame_width is accepted but has no effect on a single pixel. Configuration writes are
// always taken.
`default_nettype none

module spectrum_bar_pixel_renderer #(
  parameter int BAND_COUNT        = 32,
  parameter int INTERP_STEPS      = 4,
  parameter int VISUAL_BAND_COUNT = 128
) (
  input  logic        clk,
  input  logic        rst,
  sbr_cfg_if.sink     cfg,
  sbr_req_if.sink     req,
  sbr_rsp_if.source   rsp
);
  import sbr_pkg::*;

  logic [COORD_W-1:0]           frame_height;
  logic                         push;
  work_t                        push_item;
  logic                         space;
  logic                         pop;
  logic                         avail;
  work_t                        head;
  div_req_t                     div_req;
  logic                         div_busy;
  logic [DIV_QUOT_W-1:0]        div_quot;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FRAME_HEIGHT: frame_height <= cfg.data;
        REG_FRAME_WIDTH:  ;
        default:          ;
      endcase
    end
  end

  sbr_front #(
    .BAND_COUNT        (BAND_COUNT),
    .VISUAL_BAND_COUNT (VISUAL_BAND_COUNT)
  ) u_front (
    .req   (req),
    .space (space),
    .push  (push),
    .item  (push_item)
  );

  sbr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .space     (space),
    .pop       (pop),
    .avail     (avail),
    .head      (head)
  );

  sbr_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  sbr_back #(
    .BAND_COUNT   (BAND_COUNT),
    .INTERP_STEPS (INTERP_STEPS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .frame_height (frame_height),
    .q_avail      (avail),
    .q_item       (head),
    .q_pop        (pop),
    .div_req      (div_req),
    .div_busy     (div_busy),
    .div_quot     (div_quot),
    .rsp          (rsp)
  );

endmodule

`default_nettype wire
